@@ src/pn3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_pkg
// shared types and constants of the 3d gradient noise unit
// ----------------------------------------------------------------------------
package pn3_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF = 16;

	localparam int COORD_W   = 32;
	localparam int OUT_W     = 18;
	localparam int OUT_FRAC  = 16;
	localparam int OUT_MAX   = 131071;
	localparam int OUT_MIN   = -131072;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 24;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [7:0]          tidx;
		logic [7:0]          tval;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COORD_W-1:0]  cz;
	} item_t;

endpackage
`default_nettype wire

@@ src/pn3_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_front
// input queue and issue control with result credits
// ----------------------------------------------------------------------------
module pn3_front #(
	parameter int IN_DEPTH  = pn3_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH = pn3_pkg::OUT_DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_valid,
	output logic            s_ready,
	input  pn3_pkg::item_t  s_item,
	input  wire             out_pop,
	output logic            issue_valid,
	output pn3_pkg::item_t  issue_item
);
	import pn3_pkg::*;

	localparam int IAW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int CW  = $clog2(IN_DEPTH + 1);
	localparam int KW  = $clog2(OUT_DEPTH + 1);

	item_t          mem_q [IN_DEPTH];
	logic [IAW-1:0] wr_q;
	logic [IAW-1:0] rd_q;
	logic [CW-1:0]  cnt_q;
	logic [KW-1:0]  credit_q;
	logic           push;
	logic           issue_smp;

	function automatic logic [IAW-1:0] next_ptr(input logic [IAW-1:0] p);
		return (p == IAW'(IN_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign s_ready     = cnt_q != CW'(IN_DEPTH);
	assign push        = s_valid && s_ready;
	assign issue_item  = mem_q[rd_q];
	assign issue_valid = (cnt_q != '0) &&
		(issue_item.mode == MODE_WRITE || credit_q != KW'(OUT_DEPTH));
	assign issue_smp   = issue_valid && issue_item.mode == MODE_SAMPLE;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= s_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (issue_valid) begin
				rd_q <= next_ptr(rd_q);
			end
			case ({push, issue_valid})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			case ({issue_smp, out_pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/pn3_fade.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_fade
// six stage quintic fade 6t^5-15t^4+10t^3 in fixed point
// ----------------------------------------------------------------------------
module pn3_fade #(
	parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
	input  wire                  clk,
	input  wire [FRAC_BITS-1:0]  t,
	output logic [FRAC_BITS:0]   f
);
	localparam int F  = FRAC_BITS;
	localparam int QW = F + 6;

	logic [2*F-1:0]          p_s1;
	logic [F-1:0]            t_s1;
	logic [F:0]              t2_s2;
	logic [F-1:0]            t_s2;
	logic [F+4:0]            q_s2;
	logic [2*F:0]            p3_s3;
	logic [F+4:0]            q_s3;
	logic [F:0]              t3_s4;
	logic [F+4:0]            q_s4;
	logic [2*F+5:0]          pf_s5;
	logic [F:0]              f_s6;

	logic [2*F:0]            t2_sum;
	logic [F:0]              t2_c;
	logic signed [QW-1:0]    q_c;
	logic [2*F+1:0]          t3_sum;
	logic [2*F+6:0]          f_sum;
	logic [F+6:0]            f_c;

	assign t2_sum = {1'b0, p_s1} + ((2*F+1)'(1) << (F - 1));
	assign t2_c   = t2_sum[2*F:F];
	assign q_c    = $signed({5'b0, t2_c}) * QW'(6) - $signed({6'b0, t_s1}) * QW'(15)
		+ (QW'(10) <<< F);
	assign t3_sum = {1'b0, p3_s3} + ((2*F+2)'(1) << (F - 1));
	assign f_sum  = {1'b0, pf_s5} + ((2*F+7)'(1) << (F - 1));
	assign f_c    = f_sum[2*F+6:F];

	always_ff @(posedge clk) begin
		p_s1  <= t * t;
		t_s1  <= t;
		t2_s2 <= t2_c;
		t_s2  <= t_s1;
		q_s2  <= q_c[QW-1] ? '0 : q_c[F+4:0];
		p3_s3 <= t2_s2 * t_s2;
		q_s3  <= q_s2;
		t3_s4 <= t3_sum[2*F:F];
		q_s4  <= q_s3;
		pf_s5 <= t3_s4 * q_s4;
		f_s6  <= (f_c > (F+7)'(1) << F) ? (F+1)'(1) << F : f_c[F:0];
	end

	assign f = f_s6;

endmodule
`default_nettype wire

@@ src/pn3_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_core
// back end: replicated permutation tables, gradients, lerp tree, output scaling
// ----------------------------------------------------------------------------
module pn3_core #(
	parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          issue_valid,
	input  pn3_pkg::item_t               issue_item,
	output logic                         res_valid,
	output logic [pn3_pkg::OUT_W-1:0]    res_value
);
	import pn3_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int GW  = F + 3;
	localparam int LW  = F + 3;
	localparam int DW  = F + 4;
	localparam int PW  = 2*F + 6;
	localparam int RW  = LW + 9;
	localparam int SHR = (F > OUT_FRAC) ? (F - OUT_FRAC) : 0;
	localparam int SHL = (F < OUT_FRAC) ? (OUT_FRAC - F) : 0;
	localparam int HSH = (SHR > 0) ? (SHR - 1) : 0;

	// stage 0
	logic       wr_s0;
	logic       smp_s0;
	logic [7:0] x0;
	logic [7:0] l1_rd0_s1;
	logic [7:0] l1_rd1_s1;
	logic [7:0] l1_mem [256];

	// stage 1
	logic         wr_s1, smp_s1;
	logic [7:0]   tidx_s1, tval_s1, y_s1, z_s1;
	logic [F-1:0] fx_s1, fy_s1, fz_s1;
	logic [7:0]   l2_addr0 [2];
	logic [7:0]   l2_rd0_s2 [2];
	logic [7:0]   l2_rd1_s2 [2];

	// stage 2
	logic         wr_s2, smp_s2;
	logic [7:0]   tidx_s2, tval_s2, z_s2;
	logic [F-1:0] fx_s2, fy_s2, fz_s2;
	logic [7:0]   l3_addr0 [4];
	logic [7:0]   l3_rd0_s3 [4];
	logic [7:0]   l3_rd1_s3 [4];

	// stage 3 and on
	logic         smp_s3, smp_s4, smp_s5, smp_s6, smp_s7, smp_s8;
	logic         smp_s9, smp_s10, smp_s11, smp_s12, vld_s13;
	logic [F-1:0] fx_s3, fy_s3, fz_s3;
	logic signed [GW-1:0] g_c  [8];
	logic signed [GW-1:0] g_s4 [8];
	logic signed [GW-1:0] g_s5 [8];
	logic signed [GW-1:0] g_s6 [8];
	logic [F:0]   fu, fv, fw;
	logic [F:0]   v_s7, v_s8, w_s7, w_s8, w_s9, w_s10;
	logic signed [PW-1:0] p1_s7 [4];
	logic signed [LW-1:0] a1_s7 [4];
	logic signed [LW-1:0] l1_s8 [4];
	logic signed [PW-1:0] p2_s9 [2];
	logic signed [LW-1:0] a2_s9 [2];
	logic signed [LW-1:0] l2_s10 [2];
	logic signed [PW-1:0] p3_s11;
	logic signed [LW-1:0] a3_s11;
	logic signed [LW-1:0] r_s12;
	logic signed [RW-1:0] r_ext;
	logic signed [RW-1:0] r_scl;
	logic [OUT_W-1:0]     out_s13;

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [F:0] x, input logic signed [F:0] y,
		input logic signed [F:0] z);
		logic signed [F:0]    u;
		logic signed [F:0]    v;
		logic signed [GW-1:0] su;
		logic signed [GW-1:0] sv;
		u  = (h < 4'd8) ? x : y;
		v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		su = h[0] ? -GW'(u) : GW'(u);
		sv = h[1] ? -GW'(v) : GW'(v);
		return su + sv;
	endfunction

	function automatic logic signed [PW-1:0] lmul(input logic [F:0] t,
		input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
		logic signed [DW-1:0] d;
		d = DW'(b) - DW'(a);
		return $signed({1'b0, t}) * d;
	endfunction

	function automatic logic signed [LW-1:0] ladd(input logic signed [LW-1:0] a,
		input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		logic signed [DW-1:0] r;
		s = (p + (PW'(1) <<< (F - 1))) >>> F;
		r = DW'(a) + s[DW-1:0];
		return r[LW-1:0];
	endfunction

	assign wr_s0  = issue_valid && issue_item.mode == MODE_WRITE;
	assign smp_s0 = issue_valid && issue_item.mode == MODE_SAMPLE;
	assign x0     = issue_item.cx[F+7:F];

	// first table level
	always_ff @(posedge clk) begin
		if (wr_s0) begin
			l1_mem[issue_item.tidx] <= issue_item.tval;
		end
		l1_rd0_s1 <= l1_mem[x0];
		l1_rd1_s1 <= l1_mem[x0 + 8'd1];
	end

	always_ff @(posedge clk) begin
		tidx_s1 <= issue_item.tidx;
		tval_s1 <= issue_item.tval;
		y_s1    <= issue_item.cy[F+7:F];
		z_s1    <= issue_item.cz[F+7:F];
		fx_s1   <= issue_item.cx[F-1:0];
		fy_s1   <= issue_item.cy[F-1:0];
		fz_s1   <= issue_item.cz[F-1:0];
	end

	// second table level, copy 0 serves A, copy 1 serves B
	assign l2_addr0[0] = l1_rd0_s1 + y_s1;
	assign l2_addr0[1] = l1_rd1_s1 + y_s1;

	for (genvar k = 0; k < 2; k++) begin : g_l2
		logic [7:0] mem [256];
		logic [7:0] rd0_q;
		logic [7:0] rd1_q;
		always_ff @(posedge clk) begin
			if (wr_s1) begin
				mem[tidx_s1] <= tval_s1;
			end
			rd0_q <= mem[l2_addr0[k]];
			rd1_q <= mem[l2_addr0[k] + 8'd1];
		end
		assign l2_rd0_s2[k] = rd0_q;
		assign l2_rd1_s2[k] = rd1_q;
	end

	always_ff @(posedge clk) begin
		tidx_s2 <= tidx_s1;
		tval_s2 <= tval_s1;
		z_s2    <= z_s1;
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
		fz_s2   <= fz_s1;
	end

	// third table level, copies serve AA, BA, AB, BB
	assign l3_addr0[0] = l2_rd0_s2[0] + z_s2;
	assign l3_addr0[1] = l2_rd0_s2[1] + z_s2;
	assign l3_addr0[2] = l2_rd1_s2[0] + z_s2;
	assign l3_addr0[3] = l2_rd1_s2[1] + z_s2;

	for (genvar k = 0; k < 4; k++) begin : g_l3
		logic [7:0] mem [256];
		logic [7:0] rd0_q;
		logic [7:0] rd1_q;
		always_ff @(posedge clk) begin
			if (wr_s2) begin
				mem[tidx_s2] <= tval_s2;
			end
			rd0_q <= mem[l3_addr0[k]];
			rd1_q <= mem[l3_addr0[k] + 8'd1];
		end
		assign l3_rd0_s3[k] = rd0_q;
		assign l3_rd1_s3[k] = rd1_q;
	end

	always_ff @(posedge clk) begin
		fx_s3 <= fx_s2;
		fy_s3 <= fy_s2;
		fz_s3 <= fz_s2;
	end

	// corner bit 0 picks x-1, bit 1 picks y-1, bit 2 picks z-1
	for (genvar c = 0; c < 8; c++) begin : g_grad
		logic [7:0] h;
		assign h = c[2] ? l3_rd1_s3[c % 4] : l3_rd0_s3[c % 4];
		assign g_c[c] = grad(h[3:0],
			$signed({c[0] ? 1'b1 : 1'b0, fx_s3}),
			$signed({c[1] ? 1'b1 : 1'b0, fy_s3}),
			$signed({c[2] ? 1'b1 : 1'b0, fz_s3}));
	end

	always_ff @(posedge clk) begin
		g_s4 <= g_c;
		g_s5 <= g_s4;
		g_s6 <= g_s5;
	end

	pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk (clk),
		.t   (issue_item.cx[F-1:0]),
		.f   (fu)
	);

	pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk (clk),
		.t   (issue_item.cy[F-1:0]),
		.f   (fv)
	);

	pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
		.clk (clk),
		.t   (issue_item.cz[F-1:0]),
		.f   (fw)
	);

	// lerp tree
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			p1_s7[i] <= lmul(fu, LW'(g_s6[2*i]), LW'(g_s6[2*i+1]));
			a1_s7[i] <= LW'(g_s6[2*i]);
			l1_s8[i] <= ladd(a1_s7[i], p1_s7[i]);
		end
		v_s7  <= fv;
		v_s8  <= v_s7;
		w_s7  <= fw;
		w_s8  <= w_s7;
		w_s9  <= w_s8;
		w_s10 <= w_s9;
		for (int i = 0; i < 2; i++) begin
			p2_s9[i]  <= lmul(v_s8, l1_s8[2*i], l1_s8[2*i+1]);
			a2_s9[i]  <= l1_s8[2*i];
			l2_s10[i] <= ladd(a2_s9[i], p2_s9[i]);
		end
		p3_s11  <= lmul(w_s10, l2_s10[0], l2_s10[1]);
		a3_s11  <= l2_s10[0];
		r_s12   <= ladd(a3_s11, p3_s11);
		out_s13 <= (r_scl > RW'(OUT_MAX)) ? OUT_W'(OUT_MAX) :
			(r_scl < RW'(OUT_MIN)) ? OUT_W'(OUT_MIN) : r_scl[OUT_W-1:0];
	end

	// scale to the output format
	assign r_ext = RW'(r_s12);
	assign r_scl = (SHR > 0) ? ((r_ext + (RW'(1) <<< HSH)) >>> SHR) : (r_ext <<< SHL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			wr_s2   <= 1'b0;
			smp_s1  <= 1'b0;
			smp_s2  <= 1'b0;
			smp_s3  <= 1'b0;
			smp_s4  <= 1'b0;
			smp_s5  <= 1'b0;
			smp_s6  <= 1'b0;
			smp_s7  <= 1'b0;
			smp_s8  <= 1'b0;
			smp_s9  <= 1'b0;
			smp_s10 <= 1'b0;
			smp_s11 <= 1'b0;
			smp_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			wr_s1   <= wr_s0;
			wr_s2   <= wr_s1;
			smp_s1  <= smp_s0;
			smp_s2  <= smp_s1;
			smp_s3  <= smp_s2;
			smp_s4  <= smp_s3;
			smp_s5  <= smp_s4;
			smp_s6  <= smp_s5;
			smp_s7  <= smp_s6;
			smp_s8  <= smp_s7;
			smp_s9  <= smp_s8;
			smp_s10 <= smp_s9;
			smp_s11 <= smp_s10;
			smp_s12 <= smp_s11;
			vld_s13 <= smp_s12;
		end
	end

	assign res_valid = vld_s13;
	assign res_value = out_s13;

endmodule
`default_nettype wire

@@ src/pn3_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_outq
// result queue in front of the master side
// ----------------------------------------------------------------------------
module pn3_outq #(
	parameter int DEPTH = pn3_pkg::OUT_DEPTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	input  wire [pn3_pkg::OUT_W-1:0]    push_data,
	output logic                        m_valid,
	input  wire                         m_ready,
	output logic [pn3_pkg::OUT_W-1:0]   m_data,
	output logic                        pop
);
	import pn3_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [OUT_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign m_valid = cnt_q != '0;
	assign m_data  = mem_q[rd_q];
	assign pop     = m_valid && m_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/perlin_noise_3d_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d_unit
// 3d improved gradient noise in fixed point, stream in and stream out
// ----------------------------------------------------------------------------
// s_axis carries items: tuser 0 writes one permutation byte, tuser 1 samples.
// every sample gives one 18 bit q2.16 result on m_axis, in order; a table
// write gives none. all 256 entries must be written before sampling.
// one item per cycle is taken while m_axis keeps up; the 14 table read
// ports (two read ports per table copy; one copy at the first of the three
// hash levels, then copies doubling) let every stage of the 13 stage back
// end work each cycle. a four entry input queue decouples the front from
// the back end; the front issues a sample only while the 16 entry result
// queue has room reserved, so a stalled receiver fills the queues and then
// drops s_axis_tready. table writes need no result room but stay in order
// behind a waiting sample. reset empties both queues and the pipeline; the
// table holds stale data until rewritten.
// ----------------------------------------------------------------------------
module perlin_noise_3d_unit #(
	parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF,
	parameter int IN_DEPTH  = pn3_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH = pn3_pkg::OUT_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// table_index, table_value, coord_x, coord_y, coord_z
	input  wire [pn3_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// mode
	input  wire                              s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// noise_value, zero padding
	output logic [pn3_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
	import pn3_pkg::*;

	item_t            s_item;
	item_t            issue_item;
	logic             issue_valid;
	logic             res_valid;
	logic [OUT_W-1:0] res_value;
	logic [OUT_W-1:0] m_value;
	logic             out_pop;

	assign s_item.mode = s_axis_tuser;
	assign s_item.tidx = s_axis_tdata[7:0];
	assign s_item.tval = s_axis_tdata[15:8];
	assign s_item.cx   = s_axis_tdata[47:16];
	assign s_item.cy   = s_axis_tdata[79:48];
	assign s_item.cz   = s_axis_tdata[111:80];

	pn3_front #(.IN_DEPTH(IN_DEPTH), .OUT_DEPTH(OUT_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_item      (s_item),
		.out_pop     (out_pop),
		.issue_valid (issue_valid),
		.issue_item  (issue_item)
	);

	pn3_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue_valid (issue_valid),
		.issue_item  (issue_item),
		.res_valid   (res_valid),
		.res_value   (res_value)
	);

	pn3_outq #(.DEPTH(OUT_DEPTH)) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_value),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_value),
		.pop       (out_pop)
	);

	assign m_axis_tdata = {(M_TDATA_W - OUT_W)'(0), m_value};

endmodule
`default_nettype wire

@@ src/pn3_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_checker
// port level checks of the noise unit, bound to the top level
// ----------------------------------------------------------------------------
module pn3_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
		else $error("padding bits set");

	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid && s_axis_tready)
		else $error("queues not empty in reset");

endmodule

bind perlin_noise_3d_unit pn3_checker u_pn3_checker (.*);
`default_nettype wire
